@@ rtl/ple_pkg.sv @@
// ple_pkg: shared constants and types for the positional list engine
// no dependencies; imported by ple_ram and positional_list_engine
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;

  // request codes; the two unused codes fall to the error path
  typedef enum logic [2:0] {
    ACT_INSERT   = 3'd0,
    ACT_READ     = 3'd1,
    ACT_UPDATE   = 3'd2,
    ACT_REMOVE   = 3'd3,
    ACT_CONTAINS = 3'd4,
    ACT_FINDMIN  = 3'd5
  } action_t;

endpackage

`default_nettype wire

@@ rtl/ple_ram.sv @@
// ple_ram: simple dual-port entry store, one write and one registered read port
// depends on ple_pkg for default sizes
`timescale 1ns / 1ps
`default_nettype none

module ple_ram
  import ple_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int WIDTH = DATA_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/positional_list_engine.sv @@
// positional_list_engine: bounded ordered list of signed 32-bit values
// depends on ple_pkg and ple_ram (entry store)
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+-------------------------
//  request | start, busy, in_action, in_position, in_value      | beat when start && !busy
//  result  | out_valid, out_data_out, out_index_out, out_found, | one-cycle strobe, no stall
//          | out_status, out_count_out                          |
//
// timing: errors, update, contains on an empty list and insert at the tail answer in the
//   cycle after the beat; read goes through S_READ; insert and remove move one entry per
//   cycle through the single write port of the store; contains and find minimum scan one
//   entry per cycle from the store's read port
// reset: rst_n synchronous active low; clears the fsm, the count and the strobe;
//   the store holds garbage until written and needs no clearing
// stalls: the receiver cannot stall; busy stays high while a request walks the store
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_action,
  input  wire logic [4:0]         in_position,
  input  wire logic signed [31:0] in_value,
  // result channel
  output logic                    out_valid,
  output logic signed [31:0]      out_data_out,
  output logic [3:0]              out_index_out,
  output logic                    out_found,
  output logic                    out_status,
  output logic [4:0]              out_count_out
);

  localparam int AW = $clog2(CAPACITY);       // store index
  localparam int CW = $clog2(CAPACITY + 1);   // count, reaches CAPACITY
  localparam int EW = ((CW > 5) ? CW : 5) + 1; // compare width, room for +2

  // one-hot sequencer states
  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_READ     = 7'b0000010,
    S_SHIFT_UP = 7'b0000100,
    S_INS_FIN  = 7'b0001000,
    S_RM_HEAD  = 7'b0010000,
    S_RM_SHIFT = 7'b0100000,
    S_SCAN     = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   cur_r, cur_nxt;      // walking index into the store
  logic [AW-1:0]   pos_r, pos_nxt;
  action_t         op_r, op_nxt;
  logic [31:0]     val_r, val_nxt;
  logic [31:0]     data_r, data_nxt;    // value taken out by remove
  logic [31:0]     best_r, best_nxt;    // running minimum
  logic [AW-1:0]   idx_r, idx_nxt;

  logic            ov_r, ov_nxt;
  logic [31:0]     od_r, od_nxt;
  logic [3:0]      oi_r, oi_nxt;
  logic            of_r, of_nxt;
  logic            os_r, os_nxt;
  logic [4:0]      oc_r;

  // store port signals
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [31:0]     mem_wdata, mem_rdata;

  logic [EW-1:0]   pos_e, cnt_e, cap_e, cur_e;
  logic            more;
  logic [31:0]     cand_best;
  logic [AW-1:0]   cand_idx;

  ple_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy = (state_r != S_IDLE);

  assign pos_e = EW'(in_position);
  assign cnt_e = EW'(count_r);
  assign cap_e = EW'(CAPACITY);
  assign cur_e = EW'(cur_r);
  // another entry lies past the current one
  assign more  = (cur_e + EW'(1)) < cnt_e;

  // running minimum with the entry just read; first entry seeds it
  always_comb begin
    if ((cur_r == '0) || ($signed(mem_rdata) < $signed(best_r))) begin
      cand_best = mem_rdata;
      cand_idx  = cur_r;
    end else begin
      cand_best = best_r;
      cand_idx  = idx_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cur_nxt   = cur_r;
    pos_nxt   = pos_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    data_nxt  = data_r;
    best_nxt  = best_r;
    idx_nxt   = idx_r;
    ov_nxt    = 1'b0;
    od_nxt    = '0;
    oi_nxt    = '0;
    of_nxt    = 1'b0;
    os_nxt    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_r;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = cur_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = action_t'(in_action);
          pos_nxt = AW'(in_position);
          val_nxt = in_value;
          case (action_t'(in_action))
            ACT_INSERT: begin
              if ((pos_e > cnt_e) || (cnt_e >= cap_e)) begin
                ov_nxt = 1'b1;
                os_nxt = 1'b1;
              end else if (pos_e == cnt_e) begin
                // append at the tail, nothing to move
                mem_we    = 1'b1;
                mem_waddr = AW'(in_position);
                mem_wdata = in_value;
                count_nxt = count_r + CW'(1);
                ov_nxt    = 1'b1;
              end else begin
                // move entries up from the tail, last one first
                mem_re    = 1'b1;
                mem_raddr = AW'(count_r - CW'(1));
                cur_nxt   = AW'(count_r);
                state_nxt = S_SHIFT_UP;
              end
            end
            ACT_READ: begin
              if (pos_e >= cnt_e) begin
                ov_nxt = 1'b1;
                os_nxt = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_position);
                state_nxt = S_READ;
              end
            end
            ACT_UPDATE: begin
              ov_nxt = 1'b1;
              if (pos_e >= cnt_e) begin
                os_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_position);
                mem_wdata = in_value;
              end
            end
            ACT_REMOVE: begin
              if (pos_e >= cnt_e) begin
                ov_nxt = 1'b1;
                os_nxt = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_position);
                cur_nxt   = AW'(in_position);
                state_nxt = S_RM_HEAD;
              end
            end
            ACT_CONTAINS: begin
              if (count_r == '0) begin
                ov_nxt = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                cur_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            ACT_FINDMIN: begin
              if (count_r == '0) begin
                ov_nxt = 1'b1;
                os_nxt = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                cur_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              ov_nxt = 1'b1;
              os_nxt = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        ov_nxt    = 1'b1;
        od_nxt    = mem_rdata;
        state_nxt = S_IDLE;
      end

      S_SHIFT_UP: begin
        // entry cur-1 arrives, lands at cur
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = mem_rdata;
        if (cur_e > (EW'(pos_r) + EW'(1))) begin
          mem_re    = 1'b1;
          mem_raddr = cur_r - AW'(2);
          cur_nxt   = cur_r - AW'(1);
        end else begin
          state_nxt = S_INS_FIN;
        end
      end

      S_INS_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = val_r;
        count_nxt = count_r + CW'(1);
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end

      S_RM_HEAD: begin
        // removed value arrives; start pulling later entries down
        data_nxt = mem_rdata;
        if (more) begin
          mem_re    = 1'b1;
          mem_raddr = cur_r + AW'(1);
          state_nxt = S_RM_SHIFT;
        end else begin
          count_nxt = count_r - CW'(1);
          ov_nxt    = 1'b1;
          od_nxt    = mem_rdata;
          state_nxt = S_IDLE;
        end
      end

      S_RM_SHIFT: begin
        // entry cur+1 arrives, lands at cur
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = mem_rdata;
        if ((cur_e + EW'(2)) < cnt_e) begin
          mem_re    = 1'b1;
          mem_raddr = cur_r + AW'(2);
          cur_nxt   = cur_r + AW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
          ov_nxt    = 1'b1;
          od_nxt    = data_r;
          state_nxt = S_IDLE;
        end
      end

      S_SCAN: begin
        if (op_r == ACT_CONTAINS) begin
          if (mem_rdata == val_r) begin
            ov_nxt    = 1'b1;
            of_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else if (more) begin
            mem_re    = 1'b1;
            mem_raddr = cur_r + AW'(1);
            cur_nxt   = cur_r + AW'(1);
          end else begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          best_nxt = cand_best;
          idx_nxt  = cand_idx;
          if (more) begin
            mem_re    = 1'b1;
            mem_raddr = cur_r + AW'(1);
            cur_nxt   = cur_r + AW'(1);
          end else begin
            ov_nxt    = 1'b1;
            oi_nxt    = 4'(cand_idx);
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // working and result payload, no reset needed
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    pos_r  <= pos_nxt;
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    data_r <= data_nxt;
    best_r <= best_nxt;
    idx_r  <= idx_nxt;
    od_r   <= od_nxt;
    oi_r   <= oi_nxt;
    of_r   <= of_nxt;
    os_r   <= os_nxt;
    oc_r   <= 5'(count_nxt);
  end

  assign out_valid     = ov_r;
  assign out_data_out  = od_r;
  assign out_index_out = oi_r;
  assign out_found     = of_r;
  assign out_status    = os_r;
  assign out_count_out = oc_r;

endmodule

`default_nettype wire
